// ----- hdl/pie_pkg.sv -----
// Shared types, constants and helpers for the positional insert/erase list.
package pie_pkg;

  // Sizing of the list
  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Width used when comparing a position against the fill count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_POP_BACK   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_ERASE      = 3'd5,
    MODE_OVERWRITE  = 3'd6,
    MODE_READ       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // What every cell is told to do
  typedef enum logic [1:0] {
    CK_NONE,
    CK_LOAD_AT,
    CK_INSERT_AT,
    CK_ERASE_AT
  } cell_kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    cell_kind_t kind;
    idx_t       at;
    entry_t     word;
  } cell_cmd_t;

  // Response fields known at decode time
  typedef struct packed {
    logic               rd_en;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } rsp_meta_t;

  function automatic entry_t to_entry(logic [VALUE_W-1:0] v);
    return entry_t'(v);
  endfunction

  function automatic logic [VALUE_W-1:0] to_read(entry_t e);
    return VALUE_W'(e);
  endfunction

endpackage

// ----- hdl/positional_insert_erase_list.sv -----
// Top level of the positional insert/erase list: a row of shifting cells.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// One request is taken per cycle while req_stall is low; its response appears in the output register
// on the next cycle. All cells that move shift up or down together, on the same edge.
// rst is synchronous and clears the fill count and the response valid only;
// entry words are not reset. A stalled response holds the request side off
// only while the output register stays full.
module positional_insert_erase_list (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pie_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pie_pkg::rsp_t  rsp
);
  import pie_pkg::*;

  logic      fire;
  cell_cmd_t cmd;
  idx_t      rd_addr;
  rsp_meta_t meta;
  entry_t    words [DEPTH];
  entry_t    rd_word;

  assign req_stall = rsp_valid && rsp_stall;
  assign fire      = req_valid && !req_stall;

  pie_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .req     (req),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .meta    (meta)
  );

  // Row of cells, each wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lower;
    entry_t upper;
    if (i == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = words[i+1];
    end
    pie_cell u_cell (
      .clk   (clk),
      .idx   (idx_t'(i)),
      .cmd   (cmd),
      .lower (lower),
      .upper (upper),
      .word  (words[i])
    );
  end

  // Read select over the cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_addr == idx_t'(i)) rd_word = words[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (fire) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_value <= meta.rd_en ? to_read(rd_word) : '0;
      rsp.count      <= meta.count;
      rsp.status     <= meta.status;
    end
  end

endmodule

// ----- hdl/pie_cell.sv -----
// One list cell: holds a single entry and shifts to or from its neighbours.
module pie_cell (
  input  logic              clk,
  input  pie_pkg::idx_t     idx,
  input  pie_pkg::cell_cmd_t cmd,
  input  pie_pkg::entry_t   lower,
  input  pie_pkg::entry_t   upper,
  output pie_pkg::entry_t   word
);
  import pie_pkg::*;

  // Insert moves cells above the slot up; erase pulls cells from the slot down
  always_ff @(posedge clk) begin
    case (cmd.kind)
      CK_LOAD_AT: begin
        if (idx == cmd.at) word <= cmd.word;
      end
      CK_INSERT_AT: begin
        if (idx == cmd.at) word <= cmd.word;
        else if (idx > cmd.at) word <= lower;
      end
      CK_ERASE_AT: begin
        if (idx >= cmd.at) word <= upper;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/pie_ctrl.sv -----
// Request decoder and fill count for the list.
module pie_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  pie_pkg::req_t       req,
  output pie_pkg::cell_cmd_t  cmd,
  output pie_pkg::idx_t       rd_addr,
  output pie_pkg::rsp_meta_t  meta
);
  import pie_pkg::*;

  cnt_t    cnt;
  cnt_t    cnt_next;
  cmp_t    pos_c;
  cmp_t    cnt_c;
  cmp_t    slot;
  logic    full;
  logic    empty;
  status_t st;
  logic    rd_en;
  cell_kind_t kind;
  idx_t    at;

  assign pos_c = CMP_W'(req.position);
  assign cnt_c = CMP_W'(cnt);
  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  // Decode the request against the current count
  always_comb begin
    st       = ST_DONE;
    rd_en    = 1'b0;
    kind     = CK_NONE;
    cnt_next = cnt;
    slot     = pos_c;
    rd_addr  = idx_t'(pos_c);
    case (req.mode)
      MODE_PUSH_BACK: begin
        slot = cnt_c;
        if (full) st = ST_FULL;
        else begin
          kind     = CK_LOAD_AT;
          cnt_next = cnt + 1'b1;
        end
      end
      MODE_POP_BACK: begin
        rd_addr = idx_t'(cnt - 1'b1);
        if (empty) st = ST_RANGE;
        else begin
          rd_en    = 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      MODE_PUSH_FRONT, MODE_INSERT: begin
        if (req.mode == MODE_PUSH_FRONT) slot = '0;
        if (slot > cnt_c) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else begin
          kind     = CK_INSERT_AT;
          cnt_next = cnt + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_ERASE: begin
        if (req.mode == MODE_POP_FRONT) slot = '0;
        rd_addr = '0;
        if (slot >= cnt_c) st = ST_RANGE;
        else begin
          rd_en    = (req.mode == MODE_POP_FRONT);
          kind     = CK_ERASE_AT;
          cnt_next = cnt - 1'b1;
        end
      end
      MODE_OVERWRITE: begin
        if (slot >= cnt_c) st = ST_RANGE;
        else kind = CK_LOAD_AT;
      end
      default: begin
        if (slot >= cnt_c) st = ST_RANGE;
        else rd_en = 1'b1;
      end
    endcase
    at = idx_t'(slot);
  end

  // Broadcast to the cells only when a request is taken
  always_comb begin
    cmd.kind    = fire ? kind : CK_NONE;
    cmd.at      = at;
    cmd.word    = to_entry(req.value);
    meta.rd_en  = rd_en;
    meta.count  = COUNT_W'(cnt_next);
    meta.status = st;
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (fire) cnt <= cnt_next;
  end

endmodule

// ----- hdl/pie_check.sv -----
// Port-level checks for the positional insert/erase list, bound to the top.
module pie_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input pie_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pie_pkg::rsp_t rsp
);
  import pie_pkg::*;

  // Every taken request gives a response on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("no response after a taken request");

  // Ignored requests return a zero word
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_DONE) |-> (rsp.read_value == '0))
    else $error("ignored request returned a word");

  // Push back can only be full, never out of range
  a_push_status: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.mode == MODE_PUSH_BACK) |=> (rsp.status != ST_RANGE))
    else $error("push back reported out of range");

  // Read can never report full
  a_read_status: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.mode == MODE_READ) |=> (rsp.status != ST_FULL))
    else $error("read reported full");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind positional_insert_erase_list pie_check u_pie_check (.*);
